@@ design/rgdd_pkg.sv @@
package rgdd_pkg;

    localparam int DEF_MAX_PROCESSES = 16;
    localparam int DEF_MAX_RESOURCES = 16;

    localparam int OP_W    = 2;
    localparam int PROC_W  = 4;
    localparam int RES_W   = 4;
    localparam int CNT_W   = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [OP_W-1:0] OP_REQUEST = 2'd0;
    localparam logic [OP_W-1:0] OP_GRANT   = 2'd1;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;

    localparam int EDGE_W = 2;
    localparam logic [EDGE_W-1:0] EDGE_NONE      = 2'd0;
    localparam logic [EDGE_W-1:0] EDGE_REQUESTED = 2'd1;
    localparam logic [EDGE_W-1:0] EDGE_HELD      = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_COUNT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESOURCE_COUNT = 1'd1;

    localparam logic [CNT_W-1:0] COUNT_RESET = 5'd5;

endpackage

@@ design/rgdd_in_if.sv @@
interface rgdd_in_if;
    logic                            valid;
    logic                            ready;
    logic [rgdd_pkg::OP_W-1:0]       operation;
    logic [rgdd_pkg::PROC_W-1:0]     process;
    logic [rgdd_pkg::RES_W-1:0]      resource;

    modport source (output valid, output operation, output process, output resource,
                    input ready);
    modport sink   (input valid, input operation, input process, input resource,
                    output ready);
endinterface

@@ design/rgdd_out_if.sv @@
interface rgdd_out_if;
    logic valid;
    logic ready;
    logic deadlock;
    logic index_error;

    modport source (output valid, output deadlock, output index_error, input ready);
    modport sink   (input valid, input deadlock, input index_error, output ready);
endinterface

@@ design/resource_graph_deadlock_detector.sv @@
// grant, release, unused code or index error: the beat is taken in S_IDLE, then S_DONE parks the result
// request: the edge is written, then a search over the counts in use (P processes, R resources) follows
//   requested edges to their holders; every table read goes through the registered memory output
// throughput: one item at a time; a new beat is taken while the last result waits
// reset: async active low; then a clearing pass over all MAX_PROCESSES * 2**clog2(MAX_RESOURCES)
//   entries zeroes the edge table, no input beat is taken meanwhile
module resource_graph_deadlock_detector #(
    parameter int MAX_PROCESSES = rgdd_pkg::DEF_MAX_PROCESSES,
    parameter int MAX_RESOURCES = rgdd_pkg::DEF_MAX_RESOURCES
) (
    input  logic                             clk,
    input  logic                             rst_n,
    rgdd_in_if.sink                          in_ch,
    rgdd_out_if.source                       out_ch,
    input  logic                             cfg_we,
    input  logic [rgdd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rgdd_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // index widths into the edge table and count widths able to hold the maxima
    localparam int PW  = $clog2(MAX_PROCESSES);
    localparam int RW  = $clog2(MAX_RESOURCES);
    localparam int PCW = ($clog2(MAX_PROCESSES + 1) > rgdd_pkg::CNT_W) ?
                         $clog2(MAX_PROCESSES + 1) : rgdd_pkg::CNT_W;
    localparam int RCW = ($clog2(MAX_RESOURCES + 1) > rgdd_pkg::CNT_W) ?
                         $clog2(MAX_RESOURCES + 1) : rgdd_pkg::CNT_W;
    localparam int AW    = PW + RW;
    localparam int DEPTH = MAX_PROCESSES * (2 ** RW);
    localparam int SW    = PW + RW + PW;

    // sequencer states
    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_OUTER  = 4'd2;
    localparam logic [3:0] S_SCAN_R = 4'd3;
    localparam logic [3:0] S_WAIT_R = 4'd4;
    localparam logic [3:0] S_SCAN_Q = 4'd5;
    localparam logic [3:0] S_WAIT_Q = 4'd6;
    localparam logic [3:0] S_POP    = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    // edge table: one entry per (process, resource), row-major by process
    logic [rgdd_pkg::EDGE_W-1:0] edge_mem [DEPTH];
    logic [rgdd_pkg::EDGE_W-1:0] edge_rd_reg;
    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [rgdd_pkg::EDGE_W-1:0] mem_wdata;
    logic                        mem_re;
    logic [AW-1:0]               mem_raddr;

    // search stack: the caller frame (process, resource, holder) of each path level
    logic [SW-1:0] stk_mem [MAX_PROCESSES];
    logic [SW-1:0] stk_rd_reg;
    logic          stk_we;
    logic          stk_re;
    logic [PW-1:0] stk_raddr;

    logic [3:0]                    state_reg, state_next;
    logic [AW-1:0]                 clr_reg, clr_next;
    logic [rgdd_pkg::CNT_W-1:0]    pcnt_reg, rcnt_reg;
    logic [PCW-1:0]                outer_reg, outer_next;
    logic [PW-1:0]                 cur_p_reg, cur_p_next;
    logic [RCW-1:0]                cur_r_reg, cur_r_next;
    logic [PCW-1:0]                cur_q_reg, cur_q_next;
    logic [PW-1:0]                 sp_reg, sp_next;
    logic [MAX_PROCESSES-1:0]      seen_reg, seen_next;
    logic [MAX_PROCESSES-1:0]      path_reg, path_next;
    logic                          dead_reg, dead_next;
    logic                          err_reg, err_next;
    logic                          ovalid_reg, ovalid_next;
    logic                          odead_reg, oerr_reg;
    logic                          out_load;

    logic [PCW-1:0] n_proc;
    logic [RCW-1:0] n_res;
    logic [PCW-1:0] in_p_ext;
    logic [RCW-1:0] in_r_ext;
    logic           in_err;
    logic           in_take;
    logic [PW-1:0]  q_idx;
    logic [PW-1:0]  outer_idx;

    // counts in use, limited to the table size
    assign n_proc = (PCW'(pcnt_reg) > PCW'(MAX_PROCESSES)) ? PCW'(MAX_PROCESSES) : PCW'(pcnt_reg);
    assign n_res  = (RCW'(rcnt_reg) > RCW'(MAX_RESOURCES)) ? RCW'(MAX_RESOURCES) : RCW'(rcnt_reg);

    assign in_p_ext = PCW'(in_ch.process);
    assign in_r_ext = RCW'(in_ch.resource);
    assign in_err   = (in_p_ext >= n_proc) || (in_r_ext >= n_res);

    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_take     = in_ch.valid && in_ch.ready;

    assign q_idx     = cur_q_reg[PW-1:0];
    assign outer_idx = outer_reg[PW-1:0];

    assign stk_raddr = sp_reg - PW'(1);

    assign out_ch.valid       = ovalid_reg;
    assign out_ch.deadlock    = odead_reg;
    assign out_ch.index_error = oerr_reg;

    // output register frees the sequencer as soon as the result is parked
    assign out_load = (state_reg == S_DONE) && (!ovalid_reg || out_ch.ready);

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        outer_next = outer_reg;
        cur_p_next = cur_p_reg;
        cur_r_next = cur_r_reg;
        cur_q_next = cur_q_reg;
        sp_next    = sp_reg;
        seen_next  = seen_reg;
        path_next  = path_reg;
        dead_next  = dead_reg;
        err_next   = err_reg;
        mem_we     = 1'b0;
        mem_waddr  = clr_reg;
        mem_wdata  = rgdd_pkg::EDGE_NONE;
        mem_re     = 1'b0;
        mem_raddr  = {cur_p_reg, cur_r_reg[RW-1:0]};
        stk_we     = 1'b0;
        stk_re     = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we   = 1'b1;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_take)
                begin
                    err_next   = in_err;
                    dead_next  = 1'b0;
                    state_next = S_DONE;
                    mem_waddr  = {in_p_ext[PW-1:0], in_r_ext[RW-1:0]};
                    if (!in_err)
                    begin
                        case (in_ch.operation)
                            rgdd_pkg::OP_REQUEST:
                            begin
                                mem_we     = 1'b1;
                                mem_wdata  = rgdd_pkg::EDGE_REQUESTED;
                                outer_next = '0;
                                sp_next    = '0;
                                seen_next  = '0;
                                path_next  = '0;
                                state_next = S_OUTER;
                            end
                            rgdd_pkg::OP_GRANT:
                            begin
                                mem_we    = 1'b1;
                                mem_wdata = rgdd_pkg::EDGE_HELD;
                            end
                            rgdd_pkg::OP_RELEASE:
                            begin
                                mem_we    = 1'b1;
                                mem_wdata = rgdd_pkg::EDGE_NONE;
                            end
                            default:
                            begin
                                mem_we = 1'b0;
                            end
                        endcase
                    end
                end
            end
            S_OUTER:
            begin
                // start a walk from every process not yet seen
                if (outer_reg >= n_proc)
                begin
                    state_next = S_DONE;
                end
                else if (seen_reg[outer_idx])
                begin
                    outer_next = outer_reg + PCW'(1);
                end
                else
                begin
                    seen_next[outer_idx] = 1'b1;
                    path_next[outer_idx] = 1'b1;
                    cur_p_next = outer_idx;
                    cur_r_next = '0;
                    state_next = S_SCAN_R;
                end
            end
            S_SCAN_R:
            begin
                if (cur_r_reg >= n_res)
                begin
                    // process finished without a cycle: leave the path, return
                    path_next[cur_p_reg] = 1'b0;
                    if (sp_reg == '0)
                    begin
                        outer_next = outer_reg + PCW'(1);
                        state_next = S_OUTER;
                    end
                    else
                    begin
                        stk_re     = 1'b1;
                        sp_next    = sp_reg - PW'(1);
                        state_next = S_POP;
                    end
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = {cur_p_reg, cur_r_reg[RW-1:0]};
                    state_next = S_WAIT_R;
                end
            end
            S_WAIT_R:
            begin
                if (edge_rd_reg == rgdd_pkg::EDGE_REQUESTED)
                begin
                    cur_q_next = '0;
                    state_next = S_SCAN_Q;
                end
                else
                begin
                    cur_r_next = cur_r_reg + RCW'(1);
                    state_next = S_SCAN_R;
                end
            end
            S_SCAN_Q:
            begin
                if (cur_q_reg >= n_proc)
                begin
                    cur_r_next = cur_r_reg + RCW'(1);
                    state_next = S_SCAN_R;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = {q_idx, cur_r_reg[RW-1:0]};
                    state_next = S_WAIT_Q;
                end
            end
            S_WAIT_Q:
            begin
                if (edge_rd_reg == rgdd_pkg::EDGE_HELD)
                begin
                    if (path_reg[q_idx])
                    begin
                        dead_next  = 1'b1;
                        state_next = S_DONE;
                    end
                    else if (seen_reg[q_idx])
                    begin
                        cur_q_next = cur_q_reg + PCW'(1);
                        state_next = S_SCAN_Q;
                    end
                    else
                    begin
                        // descend into the holder
                        stk_we     = 1'b1;
                        sp_next    = sp_reg + PW'(1);
                        seen_next[q_idx] = 1'b1;
                        path_next[q_idx] = 1'b1;
                        cur_p_next = q_idx;
                        cur_r_next = '0;
                        state_next = S_SCAN_R;
                    end
                end
                else
                begin
                    cur_q_next = cur_q_reg + PCW'(1);
                    state_next = S_SCAN_Q;
                end
            end
            S_POP:
            begin
                cur_p_next = stk_rd_reg[SW-1 -: PW];
                cur_r_next = RCW'(stk_rd_reg[PW+RW-1 -: RW]);
                cur_q_next = PCW'(stk_rd_reg[PW-1:0]) + PCW'(1);
                state_next = S_SCAN_Q;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        ovalid_next = ovalid_reg;
        if (out_load)
        begin
            ovalid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            ovalid_next = 1'b0;
        end
    end

    // edge table port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            edge_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            edge_rd_reg <= edge_mem[mem_raddr];
        end
    end

    // stack port
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[sp_reg] <= {cur_p_reg, cur_r_reg[RW-1:0], q_idx};
        end
        if (stk_re)
        begin
            stk_rd_reg <= stk_mem[stk_raddr];
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcnt_reg <= rgdd_pkg::COUNT_RESET;
            rcnt_reg <= rgdd_pkg::COUNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rgdd_pkg::REG_PROCESS_COUNT:  pcnt_reg <= cfg_data;
                rgdd_pkg::REG_RESOURCE_COUNT: rcnt_reg <= cfg_data;
                default:                      pcnt_reg <= pcnt_reg;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            sp_reg     <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            sp_reg     <= sp_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // search and result payload
    always_ff @(posedge clk)
    begin
        outer_reg <= outer_next;
        cur_p_reg <= cur_p_next;
        cur_r_reg <= cur_r_next;
        cur_q_reg <= cur_q_next;
        seen_reg  <= seen_next;
        path_reg  <= path_next;
        dead_reg  <= dead_next;
        err_reg   <= err_next;
        if (out_load)
        begin
            odead_reg <= dead_reg;
            oerr_reg  <= err_reg;
        end
    end

endmodule

@@ design/rgdd_checker.sv @@
module rgdd_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic out_deadlock,
    input logic out_index_error
);

    // items accepted but not yet delivered
    logic [1:0] pend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 2'd0;
        end
        else
        begin
            pend_reg <= pend_reg + 2'((in_valid && in_ready) ? 1 : 0)
                                 - 2'((out_valid && out_ready) ? 1 : 0);
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_deadlock) && $stable(out_index_error))
        else $error("stalled result beat changed");

    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 2'd0)
        else $error("result beat without an accepted item");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("more than two items in flight");

    a_err_no_dead: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_index_error |-> !out_deadlock)
        else $error("deadlock reported on an index error");

endmodule

bind resource_graph_deadlock_detector rgdd_checker u_rgdd_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_deadlock    (out_ch.deadlock),
    .out_index_error (out_ch.index_error)
);
